/* hw/rtl/stv_pkg.sv */
// Shared types and constants of the schema table response validator.
package stv_pkg;

    localparam int MAX_MODULES_DEF     = 8;
    localparam int NAMESPACE_LIMIT_DEF = 32;
    localparam int CONTRACT_LIMIT_DEF  = 32;

    localparam logic [7:0] KIND_VALUE = 8'h81;
    localparam logic [7:0] REQUEST_ID = 8'h00;
    localparam logic [7:0] TYPE_VALUE = 8'h21;

    localparam logic [3:0] ROLE_HEADER    = 4'd0;
    localparam logic [3:0] ROLE_COUNT     = 4'd1;
    localparam logic [3:0] ROLE_NS_LEN    = 4'd2;
    localparam logic [3:0] ROLE_NS_CHAR   = 4'd3;
    localparam logic [3:0] ROLE_CON_LEN   = 4'd4;
    localparam logic [3:0] ROLE_CON_CHAR  = 4'd5;
    localparam logic [3:0] ROLE_MAJOR     = 4'd6;
    localparam logic [3:0] ROLE_MINOR     = 4'd7;
    localparam logic [3:0] ROLE_REJECTED  = 4'd8;

    typedef struct packed {
        logic [3:0] byte_role;
        logic [2:0] module_index;
        logic [4:0] char_index;
        logic [7:0] byte_value;
        logic       is_final;
        logic       accepted;
        logic [3:0] module_total;
    } stv_result_t;

endpackage

/* hw/rtl/stv_parser.sv */
// Parse state and per-item classification of payload bytes.
module stv_parser #(
    parameter int MAX_MODULES     = stv_pkg::MAX_MODULES_DEF,
    parameter int NAMESPACE_LIMIT = stv_pkg::NAMESPACE_LIMIT_DEF,
    parameter int CONTRACT_LIMIT  = stv_pkg::CONTRACT_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                frame_end,
    output stv_pkg::stv_result_t res
);
    import stv_pkg::*;

    localparam int MOD_W     = $clog2(MAX_MODULES + 1);
    localparam int LIMIT_MAX = (NAMESPACE_LIMIT > CONTRACT_LIMIT) ?
                               NAMESPACE_LIMIT : CONTRACT_LIMIT;
    localparam int STR_W     = $clog2(LIMIT_MAX);

    typedef enum logic [3:0] {
        PH_H0, PH_H1, PH_H2, PH_H3, PH_COUNT, PH_NSLEN, PH_NSCHAR,
        PH_CLEN, PH_CCHAR, PH_MAJOR, PH_MINOR, PH_DONE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [8:0]        seen_reg, seen_next;
    logic [7:0]        len_reg, len_next;
    logic [MOD_W-1:0]  mods_reg, mods_next;
    logic [MOD_W-1:0]  cur_reg, cur_next;
    logic [STR_W-1:0]  remain_reg, remain_next;
    logic [STR_W-1:0]  pos_reg, pos_next;
    logic              rej_reg, rej_next;

    logic              bad;
    logic [7:0]        left_after;
    logic [8:0]        left_wide;
    logic [MOD_W:0]    cur_inc;
    logic [7:0]        mod_wide;
    logic [7:0]        pos_wide;
    logic [7:0]        total_wide;
    logic [3:0]        role;
    logic [2:0]        mod_idx;
    logic [4:0]        ci_idx;
    logic              acc;

    always_comb
    begin
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        len_next    = len_reg;
        mods_next   = mods_reg;
        cur_next    = cur_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        rej_next    = rej_reg;
        bad         = 1'b0;
        left_after  = 8'd0;
        left_wide   = 9'(len_reg) - seen_reg - 9'd1;
        cur_inc     = (MOD_W + 1)'(cur_reg) + (MOD_W + 1)'(1);
        mod_wide    = 8'(cur_reg);
        pos_wide    = 8'(pos_reg);
        role        = ROLE_REJECTED;
        mod_idx     = 3'd0;
        ci_idx      = 5'd0;
        if (!rej_reg)
        begin
            if (phase_reg inside {PH_H0, PH_H1, PH_H2, PH_H3})
            begin
                role = ROLE_HEADER;
                case (phase_reg)
                    PH_H0:
                    begin
                        bad        = (data_byte != KIND_VALUE);
                        phase_next = PH_H1;
                    end
                    PH_H1:
                    begin
                        bad        = (data_byte != REQUEST_ID);
                        phase_next = PH_H2;
                    end
                    PH_H2:
                    begin
                        bad        = (data_byte != TYPE_VALUE);
                        phase_next = PH_H3;
                    end
                    default:
                    begin
                        bad        = (data_byte == 8'd0);
                        len_next   = data_byte;
                        seen_next  = 9'd0;
                        phase_next = PH_COUNT;
                    end
                endcase
            end
            else
            begin
                if (seen_reg >= 9'(len_reg))
                    bad = 1'b1;
                else
                    left_after = left_wide[7:0];
                case (phase_reg)
                    PH_COUNT:
                    begin
                        role = ROLE_COUNT;
                        if (9'(data_byte) > 9'(MAX_MODULES))
                            bad = 1'b1;
                        mods_next  = MOD_W'(data_byte);
                        cur_next   = '0;
                        phase_next = (data_byte == 8'd0) ? PH_DONE : PH_NSLEN;
                    end
                    PH_NSLEN, PH_CLEN:
                    begin
                        role    = (phase_reg == PH_NSLEN) ? ROLE_NS_LEN : ROLE_CON_LEN;
                        mod_idx = mod_wide[2:0];
                        if (data_byte == 8'd0 || data_byte > left_after)
                            bad = 1'b1;
                        if (phase_reg == PH_NSLEN &&
                            9'(data_byte) >= 9'(NAMESPACE_LIMIT))
                            bad = 1'b1;
                        if (phase_reg == PH_CLEN &&
                            9'(data_byte) >= 9'(CONTRACT_LIMIT))
                            bad = 1'b1;
                        remain_next = STR_W'(data_byte);
                        pos_next    = '0;
                        phase_next  = (phase_reg == PH_NSLEN) ? PH_NSCHAR : PH_CCHAR;
                    end
                    PH_NSCHAR, PH_CCHAR:
                    begin
                        role    = (phase_reg == PH_NSCHAR) ? ROLE_NS_CHAR : ROLE_CON_CHAR;
                        mod_idx = mod_wide[2:0];
                        ci_idx  = pos_wide[4:0];
                        if (data_byte == 8'd0)
                            bad = 1'b1;
                        pos_next = pos_reg + STR_W'(1);
                        if (remain_reg != '0)
                            remain_next = remain_reg - STR_W'(1);
                        if (remain_next == '0)
                            phase_next = (phase_reg == PH_NSCHAR) ? PH_CLEN : PH_MAJOR;
                    end
                    PH_MAJOR:
                    begin
                        role    = ROLE_MAJOR;
                        mod_idx = mod_wide[2:0];
                        if (left_after < 8'd1)
                            bad = 1'b1;
                        phase_next = PH_MINOR;
                    end
                    PH_MINOR:
                    begin
                        role       = ROLE_MINOR;
                        mod_idx    = mod_wide[2:0];
                        cur_next   = cur_inc[MOD_W-1:0];
                        phase_next = (cur_inc >= (MOD_W + 1)'(mods_reg)) ? PH_DONE : PH_NSLEN;
                    end
                    default:
                    begin
                        bad = 1'b1;
                    end
                endcase
                if (seen_reg != 9'h1FF)
                    seen_next = seen_reg + 9'd1;
            end
            if (bad)
            begin
                rej_next = 1'b1;
                role     = ROLE_REJECTED;
                mod_idx  = 3'd0;
                ci_idx   = 5'd0;
            end
        end

        acc        = frame_end && !rej_next && phase_next == PH_DONE &&
                     seen_next == 9'(len_next);
        total_wide = acc ? 8'(mods_next) : 8'd0;

        if (frame_end)
        begin
            phase_next  = PH_H0;
            seen_next   = 9'd0;
            len_next    = 8'd0;
            mods_next   = '0;
            cur_next    = '0;
            remain_next = '0;
            pos_next    = '0;
            rej_next    = 1'b0;
        end
    end

    assign res.byte_role    = role;
    assign res.module_index = mod_idx;
    assign res.char_index   = ci_idx;
    assign res.byte_value   = data_byte;
    assign res.is_final     = frame_end;
    assign res.accepted     = acc;
    assign res.module_total = total_wide[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_H0;
            seen_reg   <= 9'd0;
            len_reg    <= 8'd0;
            mods_reg   <= '0;
            cur_reg    <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            rej_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            len_reg    <= len_next;
            mods_reg   <= mods_next;
            cur_reg    <= cur_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            rej_reg    <= rej_next;
        end
    end

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && frame_end |=> phase_reg == PH_H0 && !rej_reg && seen_reg == 9'd0)
        else $error("state not cleared after final item");

    a_reject_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && rej_reg && !frame_end |=> rej_reg)
        else $error("rejection lost within a payload");

    a_accept_final: assert property (@(posedge clk) disable iff (!rst_n)
        res.accepted |-> res.is_final && res.byte_role != ROLE_REJECTED && !rej_reg)
        else $error("accept verdict without final valid item");

endmodule

/* hw/rtl/stv_out_buf.sv */
// Result register with skid stage for the validator output channel.
module stv_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stv_pkg::stv_result_t push_data,
    output logic                 push_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stv_pkg::stv_result_t out_data
);
    import stv_pkg::*;

    stv_result_t main_reg;
    stv_result_t skid_reg;
    logic        main_valid_reg;
    logic        skid_valid_reg;
    logic        pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push && !pop && main_valid_reg)
            skid_valid_reg <= 1'b1;
        else if (push)
            main_valid_reg <= 1'b1;
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
            main_reg <= push_data;
        else if (push)
            skid_reg <= push_data;
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds an item while output is empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("item pushed into full buffer");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        push && main_valid_reg && !out_ready |=> skid_valid_reg && main_valid_reg)
        else $error("stalled push not held in skid");

endmodule

/* hw/rtl/schema_table_response_validator.sv */
// Top level of the schema table response validator.
//
//  channel | signals                                  | dir | handshake
//  in      | data_byte, frame_end                      | in  | in_valid / in_ready
//  out     | byte_role, module_index, char_index,      | out | out_valid / out_ready
//          | byte_value, is_final, accepted,           |     |
//          | module_total                              |     |
//
// One item per cycle sustained while in_ready is high; each result is registered in the result register,
// or in the skid register while the output stalls, and is computed from the parse state registers.
// Reset clears the parse state and empties the result and skid registers.
// A stalled output is absorbed by one skid entry; in_ready drops while it is full.
module schema_table_response_validator #(
    parameter int MAX_MODULES     = stv_pkg::MAX_MODULES_DEF,
    parameter int NAMESPACE_LIMIT = stv_pkg::NAMESPACE_LIMIT_DEF,
    parameter int CONTRACT_LIMIT  = stv_pkg::CONTRACT_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] byte_role,
    output logic [2:0] module_index,
    output logic [4:0] char_index,
    output logic [7:0] byte_value,
    output logic       is_final,
    output logic       accepted,
    output logic [3:0] module_total
);
    import stv_pkg::*;

    stv_result_t res;
    stv_result_t out_data;
    logic        in_fire;

    assign in_fire = in_valid && in_ready;

    stv_parser #(
        .MAX_MODULES     (MAX_MODULES),
        .NAMESPACE_LIMIT (NAMESPACE_LIMIT),
        .CONTRACT_LIMIT  (CONTRACT_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .res       (res)
    );

    stv_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire),
        .push_data  (res),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign byte_role    = out_data.byte_role;
    assign module_index = out_data.module_index;
    assign char_index   = out_data.char_index;
    assign byte_value   = out_data.byte_value;
    assign is_final     = out_data.is_final;
    assign accepted     = out_data.accepted;
    assign module_total = out_data.module_total;

endmodule

/* bench/schema_table_response_validator_tb.sv */
// Self-checking testbench for the schema table response validator: directed and random payloads.
module schema_table_response_validator_tb;

    import stv_pkg::*;

    typedef enum logic [3:0] {
        PARSE_HDR0,
        PARSE_HDR1,
        PARSE_HDR2,
        PARSE_HDR3,
        PARSE_COUNT,
        PARSE_NS_LEN,
        PARSE_NS_CHAR,
        PARSE_CON_LEN,
        PARSE_CON_CHAR,
        PARSE_MAJOR,
        PARSE_MINOR,
        PARSE_DONE
    } parse_phase_t;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        bit          typed;
        stv_result_t want;
    } stim_item_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] byte_role;
    logic [2:0] module_index;
    logic [4:0] char_index;
    logic [7:0] byte_value;
    logic       is_final;
    logic       accepted;
    logic [3:0] module_total;

    stim_item_t  stim_q[$];
    stv_result_t expected_q[$];
    int          directed_rows;
    int          accept_idx;
    int          results_seen;
    int          mismatches;

    parse_phase_t phase;
    int           declared_len;
    int           table_seen;
    int           mods_declared;
    int           cur_module;
    int           str_left;
    int           str_pos;
    bit           rejected;

    schema_table_response_validator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_role    (byte_role),
        .module_index (module_index),
        .char_index   (char_index),
        .byte_value   (byte_value),
        .is_final     (is_final),
        .accepted     (accepted),
        .module_total (module_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void clear_parse();
        phase         = PARSE_HDR0;
        declared_len  = 0;
        table_seen    = 0;
        mods_declared = 0;
        cur_module    = 0;
        str_left      = 0;
        str_pos       = 0;
        rejected      = 1'b0;
    endfunction

    function automatic stv_result_t validate_byte(input logic [7:0] b, input logic last);
        stv_result_t r;
        bit          bad;
        int          left_after;
        int          mi;
        int          ci;
        r            = '0;
        r.byte_role  = ROLE_REJECTED;
        r.byte_value = b;
        r.is_final   = last;
        bad          = 1'b0;
        mi           = 0;
        ci           = 0;
        if (!rejected)
        begin
            if (phase <= PARSE_HDR3)
            begin
                r.byte_role = ROLE_HEADER;
                case (phase)
                    PARSE_HDR0: bad = (b != KIND_VALUE);
                    PARSE_HDR1: bad = (b != REQUEST_ID);
                    PARSE_HDR2: bad = (b != TYPE_VALUE);
                    default:
                    begin
                        bad          = (b == 8'h00);
                        declared_len = b;
                        table_seen   = 0;
                    end
                endcase
                phase = parse_phase_t'(phase + 1);
            end
            else
            begin
                left_after = 0;
                if (table_seen >= declared_len)
                    bad = 1'b1;
                else
                    left_after = declared_len - table_seen - 1;
                case (phase)
                    PARSE_COUNT:
                    begin
                        r.byte_role = ROLE_COUNT;
                        if (b > MAX_MODULES_DEF)
                            bad = 1'b1;
                        mods_declared = b;
                        cur_module    = 0;
                        phase         = (b == 8'h00) ? PARSE_DONE : PARSE_NS_LEN;
                    end
                    PARSE_NS_LEN, PARSE_CON_LEN:
                    begin
                        r.byte_role = (phase == PARSE_NS_LEN) ? ROLE_NS_LEN : ROLE_CON_LEN;
                        mi          = cur_module;
                        if (b == 8'h00 || b > left_after ||
                            b >= ((phase == PARSE_NS_LEN) ? NAMESPACE_LIMIT_DEF
                                                           : CONTRACT_LIMIT_DEF))
                            bad = 1'b1;
                        str_left = b;
                        str_pos  = 0;
                        phase    = parse_phase_t'(phase + 1);
                    end
                    PARSE_NS_CHAR, PARSE_CON_CHAR:
                    begin
                        r.byte_role = (phase == PARSE_NS_CHAR) ? ROLE_NS_CHAR : ROLE_CON_CHAR;
                        mi          = cur_module;
                        ci          = str_pos;
                        if (b == 8'h00)
                            bad = 1'b1;
                        str_pos++;
                        if (str_left > 0)
                            str_left--;
                        if (str_left == 0)
                            phase = parse_phase_t'(phase + 1);
                    end
                    PARSE_MAJOR:
                    begin
                        r.byte_role = ROLE_MAJOR;
                        mi          = cur_module;
                        if (left_after < 1)
                            bad = 1'b1;
                        phase = PARSE_MINOR;
                    end
                    PARSE_MINOR:
                    begin
                        r.byte_role = ROLE_MINOR;
                        mi          = cur_module;
                        cur_module++;
                        phase = (cur_module >= mods_declared) ? PARSE_DONE : PARSE_NS_LEN;
                    end
                    default: bad = 1'b1;
                endcase
                if (table_seen < 'h1FF)
                    table_seen++;
            end
            if (bad)
            begin
                rejected    = 1'b1;
                r.byte_role = ROLE_REJECTED;
                mi          = 0;
                ci          = 0;
            end
        end
        r.module_index = mi[2:0];
        r.char_index   = ci[4:0];
        if (last)
        begin
            if (!rejected && phase == PARSE_DONE && table_seen == declared_len)
            begin
                r.accepted     = 1'b1;
                r.module_total = mods_declared[3:0];
            end
            clear_parse();
        end
        return r;
    endfunction

    function automatic stv_result_t mk_result(input logic [3:0] role, input logic [7:0] b,
                                              input logic last, input logic acc,
                                              input logic [3:0] total);
        stv_result_t r;
        r              = '0;
        r.byte_role    = role;
        r.byte_value   = b;
        r.is_final     = last;
        r.accepted     = acc;
        r.module_total = total;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic last, input bit typed,
                                    input stv_result_t want);
        stim_item_t s;
        s.data  = b;
        s.last  = last;
        s.typed = typed;
        s.want  = want;
        stim_q.push_back(s);
    endfunction

    function automatic void add_directed();
        logic [7:0] one_module[] = '{8'h81, 8'h00, 8'h21, 8'h07, 8'h01, 8'h01, 8'hFF,
                                     8'h01, 8'h01, 8'h00, 8'hFF};
        // empty module table, accepted
        add_row(8'h81, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h81, 1'b0, 1'b0, 4'd0));
        add_row(8'h00, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h00, 1'b0, 1'b0, 4'd0));
        add_row(8'h21, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h21, 1'b0, 1'b0, 4'd0));
        add_row(8'h01, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h01, 1'b0, 1'b0, 4'd0));
        add_row(8'h00, 1'b1, 1'b1, mk_result(ROLE_COUNT, 8'h00, 1'b1, 1'b1, 4'd0));
        // wrong kind, one-byte payload
        add_row(8'h00, 1'b1, 1'b1, mk_result(ROLE_REJECTED, 8'h00, 1'b1, 1'b0, 4'd0));
        // one module, extreme byte values
        foreach (one_module[k])
            add_row(one_module[k], k == one_module.size() - 1, 1'b0, '0);
        // zero table length
        add_row(8'h81, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h81, 1'b0, 1'b0, 4'd0));
        add_row(8'h00, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h00, 1'b0, 1'b0, 4'd0));
        add_row(8'h21, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h21, 1'b0, 1'b0, 4'd0));
        add_row(8'h00, 1'b1, 1'b1, mk_result(ROLE_REJECTED, 8'h00, 1'b1, 1'b0, 4'd0));
        // module count above the limit
        add_row(8'h81, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h81, 1'b0, 1'b0, 4'd0));
        add_row(8'h00, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h00, 1'b0, 1'b0, 4'd0));
        add_row(8'h21, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'h21, 1'b0, 1'b0, 4'd0));
        add_row(8'hFF, 1'b0, 1'b1, mk_result(ROLE_HEADER, 8'hFF, 1'b0, 1'b0, 4'd0));
        add_row(8'h09, 1'b1, 1'b1, mk_result(ROLE_REJECTED, 8'h09, 1'b1, 1'b0, 4'd0));
    endfunction

    function automatic void add_random_frames(input int target);
        logic [7:0] body[$];
        logic [7:0] frame[$];
        int         total;
        int         nmod;
        int         room;
        int         extra;
        int         len;
        int         pos;
        int         n;
        total = 0;
        while (total < target)
        begin
            body.delete();
            frame.delete();
            nmod = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_MODULES_DEF)
                                               : $urandom_range(0, 2);
            room = 254 - 6 * nmod;
            body.push_back(nmod[7:0]);
            for (int m = 0; m < nmod; m++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    extra = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(0, 5);
                    if (extra > room)
                        extra = room;
                    room -= extra;
                    len = 1 + extra;
                    body.push_back(len[7:0]);
                    repeat (len) body.push_back(8'($urandom_range(1, 255)));
                end
                body.push_back(8'($urandom_range(0, 255)));
                body.push_back(8'($urandom_range(0, 255)));
            end
            frame.push_back(KIND_VALUE);
            frame.push_back(REQUEST_ID);
            frame.push_back(TYPE_VALUE);
            frame.push_back(8'(body.size()));
            foreach (body[k])
                frame.push_back(body[k]);
            // corrupt about a third of the payloads
            if ($urandom_range(0, 2) == 0)
            begin
                pos = $urandom_range(0, frame.size() - 1);
                case ($urandom_range(0, 6))
                    0: frame[pos] = 8'($urandom_range(0, 255));
                    1:
                    begin
                        n = $urandom_range(1, frame.size() - 1);
                        while (frame.size() > n)
                            void'(frame.pop_back());
                    end
                    2: repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
                    3: frame[3] = 8'($urandom_range(0, 255));
                    4: frame[pos] = 8'h00;
                    5:
                    begin
                        frame.delete();
                        n = $urandom_range(1, 8);
                        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
                        if ($urandom_range(0, 1) == 1)
                            frame[0] = KIND_VALUE;
                    end
                    default: frame[pos] = 8'($urandom_range(28, 40));
                endcase
            end
            foreach (frame[k])
                add_row(frame[k], k == frame.size() - 1, 1'b0, '0);
            total += frame.size();
        end
    endfunction

    always @(posedge clk)
    begin : track_inputs
        stv_result_t predicted;
        if (rst_n && in_valid && in_ready)
        begin
            predicted = validate_byte(data_byte, frame_end);
            if (stim_q[accept_idx].typed)
                expected_q.push_back(stim_q[accept_idx].want);
            else
                expected_q.push_back(predicted);
            accept_idx++;
        end
    end

    always @(posedge clk)
    begin : check_results
        stv_result_t got;
        stv_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{byte_role, module_index, char_index, byte_value, is_final, accepted,
                    module_total};
            results_seen++;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: role %0d byte %02h", got.byte_role,
                             got.byte_value);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.byte_role !== want.byte_role || got.module_index !== want.module_index ||
                    got.char_index !== want.char_index || got.byte_value !== want.byte_value ||
                    got.is_final !== want.is_final || got.accepted !== want.accepted ||
                    got.module_total !== want.module_total)
                begin
                    if (mismatches < 10)
                    begin
                        $display("result %0d: want role %0d mod %0d chr %0d byte %02h %s",
                                 results_seen - 1, want.byte_role, want.module_index,
                                 want.char_index, want.byte_value, "");
                        $display("    want fin %0b acc %0b tot %0d",
                                 want.is_final, want.accepted, want.module_total);
                        $display("    got  role %0d mod %0d chr %0d byte %02h",
                                 got.byte_role, got.module_index, got.char_index,
                                 got.byte_value);
                        $display("    got  fin %0b acc %0b tot %0d",
                                 got.is_final, got.accepted, got.module_total);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : receiver
        int gap;
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 500)
            begin
                gap  = 80;
                held = 1'b1;
            end
            else if (results_seen % 300 < 40)
                gap = 0;
            else
                gap = $urandom_range(0, 19);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #8000000;
        $display("** schema_table_response_validator: FAILED **");
        $finish;
    end

    initial
    begin : sender
        int  i;
        int  gap;
        bit  pause;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        data_byte    <= 8'h00;
        frame_end    <= 1'b0;
        accept_idx   = 0;
        results_seen = 0;
        mismatches   = 0;
        clear_parse();
        add_directed();
        directed_rows = stim_q.size();
        add_random_frames(1550);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        i   = 0;
        gap = $urandom_range(0, 19);
        while (i < stim_q.size())
        begin
            pause = (i == directed_rows) || (i == stim_q.size() / 2);
            if (gap > 0 || pause)
            begin
                in_valid <= 1'b0;
                if (pause)
                begin
                    @(posedge clk);
                    wait (expected_q.size() == 0);
                    @(posedge clk);
                end
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= stim_q[i].data;
            frame_end <= stim_q[i].last;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            i++;
            gap = (i % 200 < 30) ? 0 : $urandom_range(0, 19);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait (expected_q.size() == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("** schema_table_response_validator: PASSED **");
        else
            $display("** schema_table_response_validator: FAILED **");
        $finish;
    end

endmodule
